// File: rtl/last_note_priority_stack_macros.svh
// ---------------------------------------------------------------------------
// last_note_priority_stack_macros
// Assertion macros shared by the voice selector checker.
// ---------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_STACK_MACROS_SVH
`define LAST_NOTE_PRIORITY_STACK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LNP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LNP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lnp_pkg.sv
// ---------------------------------------------------------------------------
// lnp_pkg
// Field widths and event codes of the last-note-priority voice selector.
// ---------------------------------------------------------------------------
package lnp_pkg;

  // payload field widths
  localparam int ModeW = 2;
  localparam int NoteW = 7;
  localparam int VelW  = 7;

  // event kinds carried on mode
  typedef enum logic [ModeW-1:0] {
    MODE_NOTE_ON  = 2'd0,
    MODE_NOTE_OFF = 2'd1,
    MODE_ALL_OFF  = 2'd2
  } mode_e;

endpackage

// File: rtl/lnp_ram.sv
// ---------------------------------------------------------------------------
// lnp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module lnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/last_note_priority_stack.sv
// ---------------------------------------------------------------------------
// last_note_priority_stack
// Monophonic last-note-priority voice selector with stamp and velocity RAMs.
// ---------------------------------------------------------------------------
// Each input word is one event and yields exactly one output word. A note-on
// passes from acceptance through EMIT into the output register, as do
// all-off and ignored events (note at or beyond NOTE_COUNT or unused
// mode). A note-off with some note still held passes SCAN, SDONE and VREAD:
// the stamp RAM is read one entry a cycle to find the newest held note, then
// the velocity RAM is read once for the winner. With nothing left held, the
// velocity read is skipped and SDONE goes straight to EMIT. One event is in
// flight at a time; the next can be accepted only once the word is loaded
// into the output register, which may still wait for out_ready_i. So an
// event holds the input through all of its states and for as long as the
// output register stays full. Held state is a valid bit per note in
// flip-flops (cleared by reset and by all-off) in front of the stamp RAM, so
// no clearing pass is needed after reset. Equal stamps resolve to the lowest
// note number; the stamp counter saturates.
module last_note_priority_stack
  import lnp_pkg::*;
#(
  parameter int NOTE_COUNT  = 128,
  parameter int STAMP_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [NoteW-1:0] note_i,
  input  logic [VelW-1:0]  velocity_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             gate_o,
  output logic             retrigger_o,
  output logic [NoteW-1:0] active_note_o,
  output logic [VelW-1:0]  active_velocity_o
);

  localparam int AW = $clog2(NOTE_COUNT);
  localparam logic [NoteW:0] NoteLimit = (NoteW+1)'(NOTE_COUNT);
  localparam logic [AW-1:0] LastAddr = AW'(NOTE_COUNT - 1);
  localparam logic [STAMP_WIDTH-1:0] StampMax = '1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SDONE = 5'b00100,
    ST_VREAD = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [NOTE_COUNT-1:0]  held_q;
  logic [STAMP_WIDTH-1:0] next_stamp_q;
  logic [AW-1:0]          cur_note_q, cur_note_d;
  logic                   cur_vld_q, cur_vld_d;
  logic [VelW-1:0]        cur_vel_q, cur_vel_d;
  logic                   retrig_q, retrig_d;

  logic [AW-1:0]          scan_addr_q;
  logic                   rd_pend_q;
  logic                   rd_held_q;
  logic [AW-1:0]          rd_idx_q;
  logic [STAMP_WIDTH-1:0] best_stamp_q, best_stamp_d;
  logic [AW-1:0]          best_idx_q, best_idx_d;

  logic                   out_valid_q;
  logic                   gate_q, retrigger_q;
  logic [NoteW-1:0]       active_note_q;
  logic [VelW-1:0]        active_velocity_q;

  logic                   in_fire, in_range;
  logic                   do_press, do_release, do_all_off;
  logic                   out_free, emit;
  logic [STAMP_WIDTH-1:0] stamp_rdata, cand_stamp;
  logic [VelW-1:0]        vel_rdata;
  logic                   stamp_re, vel_re;

  // event decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, note_i} < NoteLimit;
  assign do_all_off = in_fire && (mode_i == MODE_ALL_OFF);
  assign do_press   = in_fire && in_range && (mode_i == MODE_NOTE_ON) && (velocity_i != '0);
  assign do_release = in_fire && in_range &&
                      (((mode_i == MODE_NOTE_ON) && (velocity_i == '0)) ||
                       (mode_i == MODE_NOTE_OFF));

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (state_q == ST_EMIT) && out_free;

  // stamp and velocity memories, written only on a press
  assign stamp_re = (state_q == ST_SCAN);
  assign vel_re   = (state_q == ST_SDONE);

  lnp_ram #(
    .WIDTH (STAMP_WIDTH),
    .DEPTH (NOTE_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (do_press),
    .waddr_i (note_i[AW-1:0]),
    .wdata_i (next_stamp_q),
    .re_i    (stamp_re),
    .raddr_i (scan_addr_q),
    .rdata_o (stamp_rdata)
  );

  lnp_ram #(
    .WIDTH (VelW),
    .DEPTH (NOTE_COUNT)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (do_press),
    .waddr_i (note_i[AW-1:0]),
    .wdata_i (velocity_i),
    .re_i    (vel_re),
    .raddr_i (best_idx_d),
    .rdata_o (vel_rdata)
  );

  // newest-stamp compare on returning read data, strict so lower notes win ties
  assign cand_stamp = rd_held_q ? stamp_rdata : '0;

  always_comb begin
    best_stamp_d = best_stamp_q;
    best_idx_d   = best_idx_q;
    if (rd_pend_q && (cand_stamp > best_stamp_q)) begin
      best_stamp_d = cand_stamp;
      best_idx_d   = rd_idx_q;
    end
  end

  // sequencer and voice update
  always_comb begin
    state_d    = state_q;
    cur_note_d = cur_note_q;
    cur_vld_d  = cur_vld_q;
    cur_vel_d  = cur_vel_q;
    retrig_d   = retrig_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          retrig_d = 1'b0;
          state_d  = ST_EMIT;
          if (do_press) begin
            cur_note_d = note_i[AW-1:0];
            cur_vel_d  = velocity_i;
            cur_vld_d  = 1'b1;
            retrig_d   = 1'b1;
          end else if (do_all_off) begin
            cur_vld_d = 1'b0;
          end else if (do_release) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_addr_q == LastAddr) begin
          state_d = ST_SDONE;
        end
      end
      ST_SDONE: begin
        if (best_stamp_d != '0) begin
          cur_note_d = best_idx_d;
          state_d    = ST_VREAD;
        end else begin
          cur_vld_d = 1'b0;
          retrig_d  = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_VREAD: begin
        cur_vel_d = vel_rdata;
        cur_vld_d = 1'b1;
        retrig_d  = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_vld_q <= cur_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_note_q <= cur_note_d;
    cur_vel_q  <= cur_vel_d;
    retrig_q   <= retrig_d;
  end

  // held flags in front of the stamp ram
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (do_all_off) begin
      held_q <= '0;
    end else if (do_press) begin
      held_q[note_i[AW-1:0]] <= 1'b1;
    end else if (do_release) begin
      held_q[note_i[AW-1:0]] <= 1'b0;
    end
  end

  // saturating press stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_stamp_q <= STAMP_WIDTH'(1);
    end else if (do_press && (next_stamp_q != StampMax)) begin
      next_stamp_q <= next_stamp_q + STAMP_WIDTH'(1);
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      rd_pend_q <= stamp_re;
      if (do_release) begin
        scan_addr_q <= '0;
      end else if (stamp_re && (scan_addr_q != LastAddr)) begin
        scan_addr_q <= scan_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= scan_addr_q;
    rd_held_q <= held_q[scan_addr_q];
    if (do_release) begin
      best_stamp_q <= '0;
      best_idx_q   <= '0;
    end else begin
      best_stamp_q <= best_stamp_d;
      best_idx_q   <= best_idx_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      gate_q            <= cur_vld_q;
      retrigger_q       <= cur_vld_q && retrig_q;
      active_note_q     <= cur_vld_q ? NoteW'(cur_note_q) : '0;
      active_velocity_q <= cur_vld_q ? cur_vel_q : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign gate_o            = gate_q;
  assign retrigger_o       = retrigger_q;
  assign active_note_o     = active_note_q;
  assign active_velocity_o = active_velocity_q;

endmodule

// File: rtl/lnp_checker.sv
// ---------------------------------------------------------------------------
// lnp_checker
// Port-level assertions for the voice selector, bound to its top level.
// ---------------------------------------------------------------------------
`include "last_note_priority_stack_macros.svh"

module lnp_checker
  import lnp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [ModeW-1:0] mode_i,
  input logic [NoteW-1:0] note_i,
  input logic [VelW-1:0]  velocity_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             gate_o,
  input logic             retrigger_o,
  input logic [NoteW-1:0] active_note_o,
  input logic [VelW-1:0]  active_velocity_o
);

  // a silent word carries no voice
  `LNP_ASSERT_NOW(a_silent_word, clk_i, rst_ni, out_valid_o && !gate_o, (active_note_o == '0) && (active_velocity_o == '0) && !retrigger_o, "silent word carries voice data")

  // a sounding voice always has a nonzero velocity
  `LNP_ASSERT_NOW(a_sound_vel, clk_i, rst_ni, out_valid_o && gate_o, active_velocity_o != '0, "sounding voice with zero velocity")

  // one event at a time: no back-to-back acceptance
  `LNP_ASSERT_NEXT(a_one_event, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input accepted while an event is in flight")

  // a stalled word holds
  `LNP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(gate_o) && $stable(active_note_o) && $stable(active_velocity_o), "stalled output word changed")

endmodule

bind last_note_priority_stack lnp_checker u_lnp_checker (.*);
